[rtl/assert_macros.svh]
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define HNS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define HNS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/hns_pkg.sv]
// shared constants, codes and types of the heightmap normal and shade block
package hns_pkg;

  // grid limits and derived widths
  localparam int MAX_SIDE    = 256;
  localparam int POS_W       = $clog2(MAX_SIDE + 2);
  localparam int ADDR_W      = $clog2(MAX_SIDE + 1);
  localparam int STORE_DEPTH = MAX_SIDE + 1;

  // field widths
  localparam int HEIGHT_W   = 16;
  localparam int GRID_W     = 9;
  localparam int INV_W      = 16;
  localparam int RGBA_W     = 32;
  localparam int NORM_W     = 16;
  localparam int NY_W       = 15;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [GRID_W-1:0] GRID_RESET = 9'd64;
  localparam logic [INV_W-1:0]  INV_RESET  = 16'd256;

  // height thresholds in q8.8 and the steepness bound in q1.14
  localparam logic [HEIGHT_W-1:0] TH_WATER  = 16'd2;
  localparam logic [HEIGHT_W-1:0] TH_SAND   = 16'd384;
  localparam logic [HEIGHT_W-1:0] TH_FOREST = 16'd1792;
  localparam logic [HEIGHT_W-1:0] TH_ROCK   = 16'd2816;
  localparam logic [NY_W-1:0]     STEEP_NY  = 15'd13108;

  // register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_SIZE = 3'd0,
    REG_INV_STEP  = 3'd1,
    REG_WATER     = 3'd2,
    REG_SAND      = 3'd3,
    REG_FOREST    = 3'd4,
    REG_ROCK      = 3'd5,
    REG_SNOW      = 3'd6
  } cfg_reg_t;

  // colour classes
  typedef enum logic [2:0] {
    CLS_WATER  = 3'd0,
    CLS_SAND   = 3'd1,
    CLS_FOREST = 3'd2,
    CLS_ROCK   = 3'd3,
    CLS_SNOW   = 3'd4
  } shade_class_t;

  // one vertex with its four neighbours
  typedef struct packed {
    logic [HEIGHT_W-1:0] centre;
    logic [HEIGHT_W-1:0] left;
    logic [HEIGHT_W-1:0] right;
    logic [HEIGHT_W-1:0] top;
    logic [HEIGHT_W-1:0] bottom;
    logic                last;
  } vertex_t;

  // shaded vertex before the colour lookup
  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic [NY_W-1:0]          normal_y;
    logic signed [NORM_W-1:0] normal_z;
    shade_class_t             cls;
    logic                     last;
  } result_t;

endpackage

[rtl/hns_if.sv]
// valid/ready channels for height samples and shaded vertices
interface hns_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [hns_pkg::HEIGHT_W-1:0] height;

  modport source (output valid, output kind, output height, input ready);
  modport sink (input valid, input kind, input height, output ready);
endinterface

interface hns_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [hns_pkg::NORM_W-1:0]  normal_x;
  logic [hns_pkg::NY_W-1:0]           normal_y;
  logic signed [hns_pkg::NORM_W-1:0]  normal_z;
  logic [hns_pkg::RGBA_W-1:0]         color_rgba;
  logic                               is_last_vertex;

  modport source (output valid, output normal_x, output normal_y, output normal_z,
                  output color_rgba, output is_last_vertex, input ready);
  modport sink (input valid, input normal_x, input normal_y, input normal_z,
                input color_rgba, input is_last_vertex, output ready);
endinterface

[rtl/hns_shade.sv]
// normal and colour class pipeline: differences, scaling, square root, division
`include "assert_macros.svh"

module hns_shade (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic                          in_valid,
  input  hns_pkg::vertex_t              vertex,
  input  logic [hns_pkg::INV_W-1:0]     inv_step,
  output logic                          out_valid,
  output hns_pkg::result_t              res
);

  localparam int SQ_STEPS   = 31;
  localparam int SQ_PER     = 2;
  localparam int SQ_STAGES  = (SQ_STEPS + SQ_PER - 1) / SQ_PER;
  localparam int DIV_STEPS  = 15;
  localparam int DIV_PER    = 2;
  localparam int DIV_STAGES = (DIV_STEPS + DIV_PER - 1) / DIV_PER;

  typedef struct packed {
    logic [15:0]             abs_x;
    logic [15:0]             abs_z;
    logic                    neg_x;
    logic                    neg_z;
    logic [15:0]             centre;
    logic                    last;
  } stage_a_t;

  typedef struct packed {
    logic [31:0]             prod_x;
    logic [31:0]             prod_z;
    logic                    neg_x;
    logic                    neg_z;
    logic [15:0]             centre;
    logic                    last;
  } stage_b_t;

  typedef struct packed {
    logic [29:0]             ax;
    logic [16:0]             ay;
    logic [29:0]             az;
    logic                    neg_x;
    logic                    neg_z;
    logic [15:0]             centre;
    logic                    last;
  } stage_c_t;

  typedef struct packed {
    logic [59:0]             sqx;
    logic [33:0]             sqy;
    logic [59:0]             sqz;
    logic [29:0]             ax;
    logic [16:0]             ay;
    logic [29:0]             az;
    logic                    neg_x;
    logic                    neg_z;
    logic [15:0]             centre;
    logic                    last;
  } stage_d_t;

  typedef struct packed {
    logic [61:0]             rad;
    logic [31:0]             rem;
    logic [30:0]             root;
  } sq_t;

  typedef struct packed {
    sq_t                     sq;
    logic [29:0]             ax;
    logic [16:0]             ay;
    logic [29:0]             az;
    logic                    neg_x;
    logic                    neg_z;
    logic [15:0]             centre;
    logic                    last;
  } sq_stage_t;

  typedef struct packed {
    logic [31:0]             rem;
    logic [14:0]             low;
    logic [14:0]             q;
  } div_t;

  typedef struct packed {
    logic [31:0]             d;
    div_t                    dx;
    div_t                    dy;
    div_t                    dz;
    logic                    neg_x;
    logic                    neg_z;
    logic [15:0]             centre;
    logic                    last;
  } div_stage_t;

  // one digit of the square root
  function automatic sq_t sqrt_step(sq_t s);
    logic [33:0] r2;
    logic [33:0] t;
    logic [33:0] diff;
    sq_t         o;
    r2    = {s.rem, s.rad[61:60]};
    t     = {1'b0, s.root, 2'b01};
    diff  = r2 - t;
    o.rad = {s.rad[59:0], 2'b00};
    if (r2 >= t) begin
      o.rem  = diff[31:0];
      o.root = {s.root[29:0], 1'b1};
    end else begin
      o.rem  = r2[31:0];
      o.root = {s.root[29:0], 1'b0};
    end
    return o;
  endfunction

  function automatic sq_stage_t sqrt_stage(sq_stage_t s, int steps);
    sq_stage_t o;
    o = s;
    for (int j = 0; j < SQ_PER; j++) begin
      if (j < steps) o.sq = sqrt_step(o.sq);
    end
    return o;
  endfunction

  // one quotient bit of the restoring division
  function automatic div_t div_step(div_t s, logic [31:0] d);
    logic [32:0] r2;
    logic [32:0] diff;
    div_t        o;
    r2    = {s.rem, s.low[14]};
    diff  = r2 - {1'b0, d};
    o.low = {s.low[13:0], 1'b0};
    if (r2 >= {1'b0, d}) begin
      o.rem = diff[31:0];
      o.q   = {s.q[13:0], 1'b1};
    end else begin
      o.rem = r2[31:0];
      o.q   = {s.q[13:0], 1'b0};
    end
    return o;
  endfunction

  function automatic div_stage_t div_stage(div_stage_t s, int steps);
    div_stage_t o;
    o = s;
    for (int j = 0; j < DIV_PER; j++) begin
      if (j < steps) begin
        o.dx = div_step(o.dx, o.d);
        o.dy = div_step(o.dy, o.d);
        o.dz = div_step(o.dz, o.d);
      end
    end
    return o;
  endfunction

  stage_a_t                  a_q, a_next;
  stage_b_t                  b_q, b_next;
  stage_c_t                  c_q, c_next;
  stage_d_t                  d_q, d_next;
  sq_stage_t                 e_next;
  div_stage_t                f_next;
  hns_pkg::result_t          res_next;
  logic                      a_valid, b_valid, c_valid, d_valid;
  logic [SQ_STAGES:0]        sq_valid;
  logic [DIV_STAGES:0]       div_valid;
  sq_stage_t                 sq_pipe [SQ_STAGES+1];
  sq_stage_t                 sq_next [SQ_STAGES];
  div_stage_t                div_pipe [DIV_STAGES+1];
  div_stage_t                div_next [DIV_STAGES];

  // central differences and their magnitudes
  always_comb begin
    logic signed [16:0] dl;
    logic signed [16:0] dv;
    logic signed [16:0] dl_abs;
    logic signed [16:0] dv_abs;
    dl             = $signed({1'b0, vertex.right}) - $signed({1'b0, vertex.left});
    dv             = $signed({1'b0, vertex.bottom}) - $signed({1'b0, vertex.top});
    dl_abs         = (dl < 0) ? -dl : dl;
    dv_abs         = (dv < 0) ? -dv : dv;
    a_next.abs_x   = dl_abs[15:0];
    a_next.abs_z   = dv_abs[15:0];
    a_next.neg_x   = dl > 0;
    a_next.neg_z   = dv > 0;
    a_next.centre  = vertex.centre;
    a_next.last    = vertex.last;
  end

  // scale by the reciprocal step
  always_comb begin
    b_next.prod_x = {16'd0, a_q.abs_x} * {16'd0, inv_step};
    b_next.prod_z = {16'd0, a_q.abs_z} * {16'd0, inv_step};
    b_next.neg_x  = a_q.neg_x;
    b_next.neg_z  = a_q.neg_z;
    b_next.centre = a_q.centre;
    b_next.last   = a_q.last;
  end

  // bring all three terms below 2^30
  always_comb begin
    logic [31:0] m;
    logic [1:0]  s;
    m = (b_q.prod_x > b_q.prod_z) ? b_q.prod_x : b_q.prod_z;
    if (m[31]) s = 2'd2;
    else if (m[30]) s = 2'd1;
    else s = 2'd0;
    c_next.ax     = 30'(b_q.prod_x >> s);
    c_next.az     = 30'(b_q.prod_z >> s);
    c_next.ay     = 17'(17'h10000 >> s);
    c_next.neg_x  = b_q.neg_x;
    c_next.neg_z  = b_q.neg_z;
    c_next.centre = b_q.centre;
    c_next.last   = b_q.last;
  end

  // squares
  always_comb begin
    d_next.sqx    = {30'd0, c_q.ax} * {30'd0, c_q.ax};
    d_next.sqz    = {30'd0, c_q.az} * {30'd0, c_q.az};
    d_next.sqy    = {17'd0, c_q.ay} * {17'd0, c_q.ay};
    d_next.ax     = c_q.ax;
    d_next.ay     = c_q.ay;
    d_next.az     = c_q.az;
    d_next.neg_x  = c_q.neg_x;
    d_next.neg_z  = c_q.neg_z;
    d_next.centre = c_q.centre;
    d_next.last   = c_q.last;
  end

  // sum of squares seeds the root
  always_comb begin
    e_next.sq.rad  = 62'(d_q.sqx) + 62'(d_q.sqz) + 62'(d_q.sqy);
    e_next.sq.rem  = '0;
    e_next.sq.root = '0;
    e_next.ax      = d_q.ax;
    e_next.ay      = d_q.ay;
    e_next.az      = d_q.az;
    e_next.neg_x   = d_q.neg_x;
    e_next.neg_z   = d_q.neg_z;
    e_next.centre  = d_q.centre;
    e_next.last    = d_q.last;
  end

  // root digits, two per stage, one in the last stage
  for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
    localparam int STEPS = (SQ_STEPS - k * SQ_PER < SQ_PER) ? SQ_STEPS - k * SQ_PER : SQ_PER;
    assign sq_next[k] = sqrt_stage(sq_pipe[k], STEPS);
  end

  // division set-up: numerator a*2^15 + l split into high part and low bits
  always_comb begin
    logic [30:0] len;
    len             = sq_pipe[SQ_STAGES].sq.root;
    f_next.d        = {len, 1'b0};
    f_next.dx.rem   = 32'(sq_pipe[SQ_STAGES].ax) + 32'(len[30:15]);
    f_next.dy.rem   = 32'(sq_pipe[SQ_STAGES].ay) + 32'(len[30:15]);
    f_next.dz.rem   = 32'(sq_pipe[SQ_STAGES].az) + 32'(len[30:15]);
    f_next.dx.low   = len[14:0];
    f_next.dy.low   = len[14:0];
    f_next.dz.low   = len[14:0];
    f_next.dx.q     = '0;
    f_next.dy.q     = '0;
    f_next.dz.q     = '0;
    f_next.neg_x    = sq_pipe[SQ_STAGES].neg_x;
    f_next.neg_z    = sq_pipe[SQ_STAGES].neg_z;
    f_next.centre   = sq_pipe[SQ_STAGES].centre;
    f_next.last     = sq_pipe[SQ_STAGES].last;
  end

  // quotient bits, two per stage, one in the last stage, three lanes
  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
    localparam int STEPS = (DIV_STEPS - k * DIV_PER < DIV_PER) ? DIV_STEPS - k * DIV_PER : DIV_PER;
    assign div_next[k] = div_stage(div_pipe[k], STEPS);
  end

  // signs and colour class
  always_comb begin
    logic [NY_W_L-1:0] nx;
    logic [NY_W_L-1:0] ny;
    logic [NY_W_L-1:0] nz;
    logic [15:0]       h;
    nx = div_pipe[DIV_STAGES].dx.q;
    ny = div_pipe[DIV_STAGES].dy.q;
    nz = div_pipe[DIV_STAGES].dz.q;
    h  = div_pipe[DIV_STAGES].centre;
    res_next.normal_x = div_pipe[DIV_STAGES].neg_x ? -$signed({1'b0, nx}) : $signed({1'b0, nx});
    res_next.normal_z = div_pipe[DIV_STAGES].neg_z ? -$signed({1'b0, nz}) : $signed({1'b0, nz});
    res_next.normal_y = ny;
    res_next.last     = div_pipe[DIV_STAGES].last;
    if (ny < hns_pkg::STEEP_NY) begin
      res_next.cls = (h <= hns_pkg::TH_ROCK) ? hns_pkg::CLS_ROCK : hns_pkg::CLS_SNOW;
    end else if (h <= hns_pkg::TH_WATER) begin
      res_next.cls = hns_pkg::CLS_WATER;
    end else if (h <= hns_pkg::TH_SAND) begin
      res_next.cls = hns_pkg::CLS_SAND;
    end else if (h <= hns_pkg::TH_FOREST) begin
      res_next.cls = hns_pkg::CLS_FOREST;
    end else if (h <= hns_pkg::TH_ROCK) begin
      res_next.cls = hns_pkg::CLS_ROCK;
    end else begin
      res_next.cls = hns_pkg::CLS_SNOW;
    end
  end

  localparam int NY_W_L = hns_pkg::NY_W;

  // valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid   <= 1'b0;
      b_valid   <= 1'b0;
      c_valid   <= 1'b0;
      d_valid   <= 1'b0;
      sq_valid  <= '0;
      div_valid <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      a_valid   <= in_valid;
      b_valid   <= a_valid;
      c_valid   <= b_valid;
      d_valid   <= c_valid;
      sq_valid  <= {sq_valid[SQ_STAGES-1:0], d_valid};
      div_valid <= {div_valid[DIV_STAGES-1:0], sq_valid[SQ_STAGES]};
      out_valid <= div_valid[DIV_STAGES];
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      a_q         <= a_next;
      b_q         <= b_next;
      c_q         <= c_next;
      d_q         <= d_next;
      sq_pipe[0]  <= e_next;
      for (int k = 0; k < SQ_STAGES; k++) sq_pipe[k+1] <= sq_next[k];
      div_pipe[0] <= f_next;
      for (int k = 0; k < DIV_STAGES; k++) div_pipe[k+1] <= div_next[k];
      res         <= res_next;
    end
  end

  // root remainder never exceeds twice the root
  `HNS_ASSERT_NOW(a_sqrt_rem, sq_valid[SQ_STAGES], sq_pipe[SQ_STAGES].sq.rem <= {sq_pipe[SQ_STAGES].sq.root, 1'b0}, "square root remainder out of range")
  // division remainders stay below the divisor
  `HNS_ASSERT_NOW(a_div_rem, div_valid[DIV_STAGES], (div_pipe[DIV_STAGES].dx.rem < div_pipe[DIV_STAGES].d) && (div_pipe[DIV_STAGES].dy.rem < div_pipe[DIV_STAGES].d) && (div_pipe[DIV_STAGES].dz.rem < div_pipe[DIV_STAGES].d), "division remainder not below divisor")
  // a held pipeline keeps its last stage
  `HNS_ASSERT_NEXT(a_hold, !adv && out_valid, out_valid && $stable(res), "result changed while held")

endmodule

[rtl/heightmap_normal_and_shade_top.sv]
// top level: configuration, row stores, raster counters and output skid stage
//
//  channel      dir  handshake          payload
//  sample_in    in   valid/ready        kind, height
//  vertex_out   out  valid/ready        normal_x/y/z, color_rgba, is_last_vertex
//  config       in   cfg_we only        cfg_index, cfg_data
//
// one item per cycle while the output is not stalled; an accepted item passes
// through the row store read, the arithmetic stages and the output register.
// the arithmetic includes 16 square root stages and 8 division stages.
// rst clears the counters, configuration registers and valid bits; the row stores hold no reset.
// a stalled output fills the skid register, after which sample_in.ready drops
// and the whole pipeline holds until the skid drains.
`include "assert_macros.svh"

module heightmap_normal_and_shade_top (
  input  logic                             clk,
  input  logic                             rst,
  hns_in_if.sink                           sample_in,
  hns_out_if.source                        vertex_out,
  input  logic                             cfg_we,
  input  logic [hns_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [hns_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int POS_W  = hns_pkg::POS_W;
  localparam int ADDR_W = hns_pkg::ADDR_W;
  localparam int H_W    = hns_pkg::HEIGHT_W;

  logic [hns_pkg::GRID_W-1:0]  grid_size;
  logic [hns_pkg::INV_W-1:0]   inv_double_step;
  logic [hns_pkg::RGBA_W-1:0]  water_rgba, sand_rgba, forest_rgba, rock_rgba, snow_rgba;

  logic [POS_W-1:0]  row, col, flush_pos;
  logic [POS_W-1:0]  size_eff, pos, pos_inc;
  logic [ADDR_W-1:0] addr_c, addr_r;
  logic              adv, acc, samp_ok, emit_s, emit_f, at_right, f_last, restart;

  logic [H_W-1:0]    middle_store [hns_pkg::STORE_DEPTH];
  logic [H_W-1:0]    upper_store [hns_pkg::STORE_DEPTH];
  logic [H_W-1:0]    rd_centre, rd_right, rd_upper, prev_centre;

  logic              s1_valid, s1_flush, s1_row_one, s1_at_left, s1_at_right, s1_last;
  logic [H_W-1:0]    s1_height;
  logic [ADDR_W-1:0] s1_addr;
  logic              up_we;

  hns_pkg::vertex_t  vertex;
  hns_pkg::result_t  sh_res, out_res, skid_res;
  logic              sh_valid, out_valid, skid_valid, out_load, skid_load;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size       <= hns_pkg::GRID_RESET;
      inv_double_step <= hns_pkg::INV_RESET;
      water_rgba      <= '0;
      sand_rgba       <= '0;
      forest_rgba     <= '0;
      rock_rgba       <= '0;
      snow_rgba       <= '0;
    end else if (cfg_we) begin
      case (hns_pkg::cfg_reg_t'(cfg_index))
        hns_pkg::REG_GRID_SIZE: grid_size       <= cfg_data[hns_pkg::GRID_W-1:0];
        hns_pkg::REG_INV_STEP:  inv_double_step <= cfg_data[hns_pkg::INV_W-1:0];
        hns_pkg::REG_WATER:     water_rgba      <= cfg_data;
        hns_pkg::REG_SAND:      sand_rgba       <= cfg_data;
        hns_pkg::REG_FOREST:    forest_rgba     <= cfg_data;
        hns_pkg::REG_ROCK:      rock_rgba       <= cfg_data;
        hns_pkg::REG_SNOW:      snow_rgba       <= cfg_data;
        default: ;
      endcase
    end
  end

  // grid size clamped to one..max side
  always_comb begin
    if (grid_size == '0) size_eff = POS_W'(1);
    else if (32'(grid_size) > hns_pkg::MAX_SIDE) size_eff = POS_W'(hns_pkg::MAX_SIDE);
    else size_eff = POS_W'(grid_size);
  end

  // accept decode and store addresses
  assign adv      = !skid_valid;
  assign acc      = sample_in.valid && adv;
  assign samp_ok  = !sample_in.kind && (row <= size_eff);
  assign emit_s   = samp_ok && (row != '0);
  assign emit_f   = sample_in.kind && (row > size_eff) && (flush_pos <= size_eff);
  assign pos      = sample_in.kind ? flush_pos : col;
  assign pos_inc  = pos + POS_W'(1);
  assign at_right = pos == size_eff;
  assign f_last   = flush_pos == size_eff;
  assign addr_c   = pos[ADDR_W-1:0];
  assign addr_r   = at_right ? addr_c : pos_inc[ADDR_W-1:0];
  assign restart  = cfg_we && (hns_pkg::cfg_reg_t'(cfg_index) == hns_pkg::REG_GRID_SIZE);
  assign sample_in.ready = adv;

  // raster counters
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      row       <= '0;
      col       <= '0;
      flush_pos <= '0;
    end else if (acc) begin
      if (samp_ok) begin
        if (col >= size_eff) begin
          col <= '0;
          row <= row + POS_W'(1);
        end else begin
          col <= col + POS_W'(1);
        end
      end else if (emit_f) begin
        if (f_last) begin
          row       <= '0;
          col       <= '0;
          flush_pos <= '0;
        end else begin
          flush_pos <= flush_pos + POS_W'(1);
        end
      end
    end
  end

  // middle row store: two reads, new sample written in place
  always_ff @(posedge clk) begin
    if (acc && samp_ok) middle_store[addr_c] <= sample_in.height;
    if (acc) begin
      rd_centre <= middle_store[addr_c];
      rd_right  <= middle_store[addr_r];
    end
  end

  // upper row store: takes the old centre once the vertex moves on
  assign up_we = adv && s1_valid && !s1_flush;
  always_ff @(posedge clk) begin
    if (up_we) upper_store[s1_addr] <= rd_centre;
    if (acc) rd_upper <= upper_store[addr_c];
  end

  // read stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= acc && (emit_s || emit_f);
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_flush    <= sample_in.kind;
      s1_row_one  <= row == POS_W'(1);
      s1_at_left  <= pos == '0;
      s1_at_right <= at_right;
      s1_last     <= sample_in.kind && f_last;
      s1_height   <= sample_in.height;
      s1_addr     <= addr_c;
    end
    if (adv && s1_valid) prev_centre <= rd_centre;
  end

  // neighbours, edges replaced by the centre
  always_comb begin
    vertex.centre = rd_centre;
    vertex.left   = s1_at_left ? rd_centre : prev_centre;
    vertex.right  = s1_at_right ? rd_centre : rd_right;
    vertex.top    = (!s1_flush && s1_row_one) ? rd_centre : rd_upper;
    vertex.bottom = s1_flush ? rd_centre : s1_height;
    vertex.last   = s1_last;
  end

  hns_shade u_shade (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (s1_valid),
    .vertex    (vertex),
    .inv_step  (inv_double_step),
    .out_valid (sh_valid),
    .res       (sh_res)
  );

  // output register with skid beat
  assign out_load  = !out_valid || vertex_out.ready;
  assign skid_load = !out_load && sh_valid && !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_load) begin
      out_valid  <= skid_valid || sh_valid;
      skid_valid <= 1'b0;
    end else if (skid_load) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_res <= skid_valid ? skid_res : sh_res;
    if (skid_load) skid_res <= sh_res;
  end

  // colour lookup and port drive
  always_comb begin
    case (out_res.cls)
      hns_pkg::CLS_WATER:  vertex_out.color_rgba = water_rgba;
      hns_pkg::CLS_SAND:   vertex_out.color_rgba = sand_rgba;
      hns_pkg::CLS_FOREST: vertex_out.color_rgba = forest_rgba;
      hns_pkg::CLS_ROCK:   vertex_out.color_rgba = rock_rgba;
      default:             vertex_out.color_rgba = snow_rgba;
    endcase
  end

  assign vertex_out.valid          = out_valid;
  assign vertex_out.normal_x       = out_res.normal_x;
  assign vertex_out.normal_y       = out_res.normal_y;
  assign vertex_out.normal_z       = out_res.normal_z;
  assign vertex_out.is_last_vertex = out_res.last;

  // skid beat only exists behind a waiting output beat
  `HNS_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid beat without output beat")
  // counters stay inside the frame
  `HNS_ASSERT_NOW(a_pos_bound, 1'b1, (row <= size_eff + POS_W'(1)) && (col <= size_eff) && (flush_pos <= size_eff), "raster position beyond frame")
  // final flush starts a new frame
  `HNS_ASSERT_NEXT(a_frame_restart, acc && emit_f && f_last && !restart, (row == '0) && (flush_pos == '0), "frame did not restart after last vertex")

endmodule
